FILE: rtl/vtpp_pkg.sv
// Shared constants, types and register codes of the view transform and projection block.
package vtpp_pkg;

   // Lanes of the lateral datapath: x follows the right axis, y the up axis.
   localparam int LANES  = 2;
   localparam int LANE_X = 0;
   localparam int LANE_Y = 1;
   localparam int AXIS_F = 2;

   // Field and datapath widths
   localparam int PT_W       = 20;
   localparam int REL_W      = PT_W + 1;
   localparam int AX_W       = 16;
   localparam int PROD_W     = REL_W + AX_W;
   localparam int SUM_W      = PROD_W + 2;
   localparam int DSUM_W     = SUM_W + 1;
   localparam int DIST_W     = 18;
   localparam int FRAC_SHIFT = 14;
   localparam int DEPTH_W    = 37;
   localparam int MAG_W      = 37;
   localparam int GAIN_W     = 24;
   localparam int SCALE_W    = 16;
   localparam int MLO_W      = 19;
   localparam int MHI_W      = MAG_W - MLO_W;
   localparam int PLO_W      = MLO_W + GAIN_W;
   localparam int PHI_W      = MHI_W + GAIN_W;
   localparam int A_W        = MAG_W + GAIN_W;
   localparam int ALO_W      = 31;
   localparam int AHI_W      = A_W - ALO_W;
   localparam int SLO_W      = ALO_W + SCALE_W;
   localparam int SHI_W      = AHI_W + SCALE_W;
   localparam int NUM_W      = A_W + SCALE_W;
   localparam int DEN_SHIFT  = 16;
   localparam int QUO_W      = 17;
   localparam int ORG_W      = 16;
   localparam int OUT_W      = 16;
   localparam int TERM_W     = QUO_W + 1;
   localparam int OSUM_W     = TERM_W + 1;

   // Configuration register widths
   localparam int POS_W      = 3 * PT_W;
   localparam int AXIS_W     = 3 * AX_W;
   localparam int CSR_DATA_W = POS_W;
   localparam int CSR_IDX_W  = 3;

   // Pipeline map
   localparam int VIEW_FIRST = 0;
   localparam int VIEW_N     = 4;
   localparam int SCL_FIRST  = VIEW_FIRST + VIEW_N;
   localparam int SCL_N      = 4;
   localparam int DIV_FIRST  = SCL_FIRST + SCL_N;
   localparam int DIV_N      = QUO_W + 1;
   localparam int OUT_STAGE  = DIV_FIRST + DIV_N;
   localparam int NST        = OUT_STAGE + 1;

   // Reset values of the registers
   localparam logic [POS_W-1:0]  CAMERA_POSITION_RST = 60'd971776;
   localparam logic [AXIS_W-1:0] RIGHT_AXIS_RST      = 48'd211106232532992;
   localparam logic [AXIS_W-1:0] UP_AXIS_RST         = 48'd1073741824;
   localparam logic [AXIS_W-1:0] FORWARD_AXIS_RST    = 48'd16384;
   localparam logic [DIST_W-1:0] ORBIT_DISTANCE_RST  = 18'd76800;
   localparam logic [DIST_W-1:0] NEAR_LIMIT_RST      = 18'd256;
   localparam logic [GAIN_W-1:0] FOCAL_GAIN_RST      = 24'd128000;

   localparam logic signed [OUT_W-1:0] SAT_MAX = 16'sh7FFF;
   localparam logic signed [OUT_W-1:0] SAT_MIN = 16'sh8000;
   localparam logic [DEPTH_W-1:0]      DEPTH_MIN = DEPTH_W'(1) << FRAC_SHIFT;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CAMERA_POSITION = 3'd0,
      REG_RIGHT_AXIS      = 3'd1,
      REG_UP_AXIS         = 3'd2,
      REG_FORWARD_AXIS    = 3'd3,
      REG_ORBIT_DISTANCE  = 3'd4,
      REG_NEAR_LIMIT      = 3'd5,
      REG_FOCAL_GAIN      = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [PT_W-1:0] cam_x;
      logic signed [PT_W-1:0] cam_y;
      logic signed [PT_W-1:0] cam_z;
      logic signed [AX_W-1:0] rgt_x;
      logic signed [AX_W-1:0] rgt_y;
      logic signed [AX_W-1:0] rgt_z;
      logic signed [AX_W-1:0] up_x;
      logic signed [AX_W-1:0] up_y;
      logic signed [AX_W-1:0] up_z;
      logic signed [AX_W-1:0] fwd_x;
      logic signed [AX_W-1:0] fwd_y;
      logic signed [AX_W-1:0] fwd_z;
      logic [DIST_W-1:0]      orbit;
      logic [DIST_W-1:0]      near;
      logic [GAIN_W-1:0]      gain;
   } cfg_type;

   typedef struct packed {
      logic [MAG_W-1:0] mag;
      logic             neg;
      logic [ORG_W-1:0] org;
   } view_lane_type;

   typedef struct packed {
      logic [DEPTH_W-1:0]               depth;
      logic [SCALE_W-1:0]               scale;
      view_lane_type [LANES-1:0]        lane;
   } view_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic             neg;
      logic [ORG_W-1:0] org;
   } num_lane_type;

   typedef struct packed {
      logic [DEPTH_W-1:0]       depth;
      num_lane_type [LANES-1:0] lane;
   } num_type;

   typedef struct packed {
      logic [QUO_W-1:0] quo;
      logic             ovf;
      logic             neg;
      logic [ORG_W-1:0] org;
   } quo_lane_type;

   typedef struct packed {
      quo_lane_type [LANES-1:0] lane;
   } quo_type;

endpackage

FILE: rtl/vtpp_view.sv
// Relative point, basis dot products, clamped depth and lateral magnitudes (four stages).
module vtpp_view (
   input  logic                                 clock,
   input  vtpp_pkg::cfg_type                    cfg,
   input  logic [vtpp_pkg::VIEW_N-1:0]          en,
   input  logic signed [vtpp_pkg::PT_W-1:0]     point_x,
   input  logic signed [vtpp_pkg::PT_W-1:0]     point_y,
   input  logic signed [vtpp_pkg::PT_W-1:0]     point_z,
   input  logic signed [vtpp_pkg::ORG_W-1:0]    org_x,
   input  logic signed [vtpp_pkg::ORG_W-1:0]    org_y,
   input  logic [vtpp_pkg::SCALE_W-1:0]         scale,
   output vtpp_pkg::view_type                   view
);

   logic signed [vtpp_pkg::PT_W-1:0]   pt [3];
   logic signed [vtpp_pkg::PT_W-1:0]   cam [3];
   logic signed [vtpp_pkg::AX_W-1:0]   axis_m [3][3];
   logic signed [vtpp_pkg::REL_W-1:0]  rel_in [3];
   logic signed [vtpp_pkg::REL_W-1:0]  rel_ff [3];
   logic signed [vtpp_pkg::PROD_W-1:0] prod_in [3][3];
   logic signed [vtpp_pkg::PROD_W-1:0] prod_ff [3][3];
   logic signed [vtpp_pkg::SUM_W-1:0]  sum_in [3];
   logic signed [vtpp_pkg::SUM_W-1:0]  sum_ff [3];
   logic signed [vtpp_pkg::SUM_W-1:0]  absv [vtpp_pkg::LANES];
   logic signed [vtpp_pkg::DSUM_W-1:0] dsum;
   logic signed [vtpp_pkg::DSUM_W-1:0] lim;
   logic signed [vtpp_pkg::DSUM_W-1:0] dsel;
   logic [vtpp_pkg::DIST_W-1:0]        near_nz;
   logic [vtpp_pkg::ORG_W-1:0]         org_ff [3][vtpp_pkg::LANES];
   logic [vtpp_pkg::SCALE_W-1:0]       scl_ff [3];
   vtpp_pkg::view_type                 view_in;
   vtpp_pkg::view_type                 view_ff;

   always_comb begin
      pt[0] = point_x;
      pt[1] = point_y;
      pt[2] = point_z;
      cam[0] = cfg.cam_x;
      cam[1] = cfg.cam_y;
      cam[2] = cfg.cam_z;
      axis_m[0][0] = cfg.rgt_x;
      axis_m[0][1] = cfg.rgt_y;
      axis_m[0][2] = cfg.rgt_z;
      axis_m[1][0] = cfg.up_x;
      axis_m[1][1] = cfg.up_y;
      axis_m[1][2] = cfg.up_z;
      axis_m[2][0] = cfg.fwd_x;
      axis_m[2][1] = cfg.fwd_y;
      axis_m[2][2] = cfg.fwd_z;
   end

   // stage 0: point minus camera
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         rel_in[c] = vtpp_pkg::REL_W'(pt[c]) - vtpp_pkg::REL_W'(cam[c]);
      end
   end

   // stage 1: nine products, axis a by component c
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[a][c] = vtpp_pkg::PROD_W'(rel_ff[c]) * vtpp_pkg::PROD_W'(axis_m[a][c]);
         end
      end
   end

   // stage 2: dot products
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         sum_in[a] = vtpp_pkg::SUM_W'(prod_ff[a][0]) + vtpp_pkg::SUM_W'(prod_ff[a][1])
                   + vtpp_pkg::SUM_W'(prod_ff[a][2]);
      end
   end

   // stage 3: depth with near clamp, sign and magnitude of the lateral terms
   always_comb begin
      near_nz = (cfg.near == '0) ? vtpp_pkg::DIST_W'(1) : cfg.near;
      dsum = vtpp_pkg::DSUM_W'(sum_ff[vtpp_pkg::AXIS_F])
           + $signed({{(vtpp_pkg::DSUM_W - vtpp_pkg::DIST_W - vtpp_pkg::FRAC_SHIFT){1'b0}},
                      cfg.orbit, {vtpp_pkg::FRAC_SHIFT{1'b0}}});
      lim  = $signed({{(vtpp_pkg::DSUM_W - vtpp_pkg::DIST_W - vtpp_pkg::FRAC_SHIFT){1'b0}},
                      near_nz, {vtpp_pkg::FRAC_SHIFT{1'b0}}});
      dsel = (dsum < lim) ? lim : dsum;
      view_in.depth = dsel[vtpp_pkg::DEPTH_W-1:0];
      view_in.scale = scl_ff[2];
      for (int l = 0; l < vtpp_pkg::LANES; l++) begin
         absv[l] = sum_ff[l][vtpp_pkg::SUM_W-1] ? -sum_ff[l] : sum_ff[l];
         view_in.lane[l].mag = absv[l][vtpp_pkg::MAG_W-1:0];
         view_in.lane[l].neg = sum_ff[l][vtpp_pkg::SUM_W-1];
         view_in.lane[l].org = org_ff[2][l];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rel_ff <= rel_in;
         org_ff[0][vtpp_pkg::LANE_X] <= org_x;
         org_ff[0][vtpp_pkg::LANE_Y] <= org_y;
         scl_ff[0] <= scale;
      end
      if (en[1]) begin
         prod_ff <= prod_in;
         org_ff[1] <= org_ff[0];
         scl_ff[1] <= scl_ff[0];
      end
      if (en[2]) begin
         sum_ff <= sum_in;
         org_ff[2] <= org_ff[1];
         scl_ff[2] <= scl_ff[1];
      end
      if (en[3]) begin
         view_ff <= view_in;
      end
   end

   assign view = view_ff;

endmodule

FILE: rtl/vtpp_scale.sv
// Numerator |v| * gain * scale built from split products (four stages).
module vtpp_scale (
   input  logic                          clock,
   input  logic [vtpp_pkg::GAIN_W-1:0]   gain,
   input  logic [vtpp_pkg::SCL_N-1:0]    en,
   input  vtpp_pkg::view_type            view,
   output vtpp_pkg::num_type             num
);

   logic [vtpp_pkg::PLO_W-1:0]   plo_in [vtpp_pkg::LANES];
   logic [vtpp_pkg::PLO_W-1:0]   plo_ff [vtpp_pkg::LANES];
   logic [vtpp_pkg::PHI_W-1:0]   phi_in [vtpp_pkg::LANES];
   logic [vtpp_pkg::PHI_W-1:0]   phi_ff [vtpp_pkg::LANES];
   logic [vtpp_pkg::A_W-1:0]     a_in [vtpp_pkg::LANES];
   logic [vtpp_pkg::A_W-1:0]     a_ff [vtpp_pkg::LANES];
   logic [vtpp_pkg::SLO_W-1:0]   slo_in [vtpp_pkg::LANES];
   logic [vtpp_pkg::SLO_W-1:0]   slo_ff [vtpp_pkg::LANES];
   logic [vtpp_pkg::SHI_W-1:0]   shi_in [vtpp_pkg::LANES];
   logic [vtpp_pkg::SHI_W-1:0]   shi_ff [vtpp_pkg::LANES];
   logic [vtpp_pkg::DEPTH_W-1:0] dep_ff [3];
   logic [vtpp_pkg::LANES-1:0]   sgn_ff [3];
   logic [vtpp_pkg::ORG_W-1:0]   org_ff [3][vtpp_pkg::LANES];
   logic [vtpp_pkg::SCALE_W-1:0] scl_ff [2];
   vtpp_pkg::num_type            num_in;
   vtpp_pkg::num_type            num_ff;

   always_comb begin
      for (int l = 0; l < vtpp_pkg::LANES; l++) begin
         // |v| split low/high against the gain
         plo_in[l] = vtpp_pkg::PLO_W'(view.lane[l].mag[vtpp_pkg::MLO_W-1:0])
                   * vtpp_pkg::PLO_W'(gain);
         phi_in[l] = vtpp_pkg::PHI_W'(view.lane[l].mag[vtpp_pkg::MAG_W-1:vtpp_pkg::MLO_W])
                   * vtpp_pkg::PHI_W'(gain);
         a_in[l] = (vtpp_pkg::A_W'(phi_ff[l]) << vtpp_pkg::MLO_W) + vtpp_pkg::A_W'(plo_ff[l]);
         // product split low/high against the scale
         slo_in[l] = vtpp_pkg::SLO_W'(a_ff[l][vtpp_pkg::ALO_W-1:0])
                   * vtpp_pkg::SLO_W'(scl_ff[1]);
         shi_in[l] = vtpp_pkg::SHI_W'(a_ff[l][vtpp_pkg::A_W-1:vtpp_pkg::ALO_W])
                   * vtpp_pkg::SHI_W'(scl_ff[1]);
         num_in.lane[l].num = (vtpp_pkg::NUM_W'(shi_ff[l]) << vtpp_pkg::ALO_W)
                            + vtpp_pkg::NUM_W'(slo_ff[l]);
         num_in.lane[l].neg = sgn_ff[2][l];
         num_in.lane[l].org = org_ff[2][l];
      end
      num_in.depth = dep_ff[2];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
         dep_ff[0] <= view.depth;
         scl_ff[0] <= view.scale;
         for (int l = 0; l < vtpp_pkg::LANES; l++) begin
            sgn_ff[0][l] <= view.lane[l].neg;
            org_ff[0][l] <= view.lane[l].org;
         end
      end
      if (en[1]) begin
         a_ff <= a_in;
         dep_ff[1] <= dep_ff[0];
         sgn_ff[1] <= sgn_ff[0];
         org_ff[1] <= org_ff[0];
         scl_ff[1] <= scl_ff[0];
      end
      if (en[2]) begin
         slo_ff <= slo_in;
         shi_ff <= shi_in;
         dep_ff[2] <= dep_ff[1];
         sgn_ff[2] <= sgn_ff[1];
         org_ff[2] <= org_ff[1];
      end
      if (en[3]) begin
         num_ff <= num_in;
      end
   end

   assign num = num_ff;

endmodule

FILE: rtl/vtpp_div.sv
// Restoring divider by depth * 2^16: overflow check then one quotient bit per stage.
module vtpp_div (
   input  logic                          clock,
   input  logic [vtpp_pkg::DIV_N-1:0]    en,
   input  vtpp_pkg::num_type             num,
   output vtpp_pkg::quo_type             quo
);

   logic [vtpp_pkg::NUM_W-1:0]   rem_ff [vtpp_pkg::QUO_W][vtpp_pkg::LANES];
   logic [vtpp_pkg::DEPTH_W-1:0] den_ff [vtpp_pkg::QUO_W];
   logic [vtpp_pkg::QUO_W-1:0]   q_ff   [vtpp_pkg::DIV_N][vtpp_pkg::LANES];
   logic [vtpp_pkg::LANES-1:0]   ovf_ff [vtpp_pkg::DIV_N];
   logic [vtpp_pkg::LANES-1:0]   sgn_ff [vtpp_pkg::DIV_N];
   logic [vtpp_pkg::ORG_W-1:0]   org_ff [vtpp_pkg::DIV_N][vtpp_pkg::LANES];
   logic [vtpp_pkg::NUM_W-1:0]   top_den;

   // quotient of 2^17 or more: the offset saturates whatever the origin
   assign top_den = vtpp_pkg::NUM_W'(num.depth) << (vtpp_pkg::DEN_SHIFT + vtpp_pkg::QUO_W);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         den_ff[0] <= num.depth;
         for (int l = 0; l < vtpp_pkg::LANES; l++) begin
            rem_ff[0][l] <= num.lane[l].num;
            q_ff[0][l]   <= '0;
            ovf_ff[0][l] <= num.lane[l].num >= top_den;
            sgn_ff[0][l] <= num.lane[l].neg;
            org_ff[0][l] <= num.lane[l].org;
         end
      end
   end

   for (genvar k = 1; k < vtpp_pkg::DIV_N; k++) begin : g_step
      localparam int BIT = vtpp_pkg::QUO_W - k;
      logic [vtpp_pkg::NUM_W-1:0] trial;
      logic [vtpp_pkg::LANES-1:0] ge;

      assign trial = vtpp_pkg::NUM_W'(den_ff[k-1]) << (vtpp_pkg::DEN_SHIFT + BIT);
      for (genvar l = 0; l < vtpp_pkg::LANES; l++) begin : g_cmp
         assign ge[l] = rem_ff[k-1][l] >= trial;
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            for (int l = 0; l < vtpp_pkg::LANES; l++) begin
               q_ff[k][l] <= q_ff[k-1][l] | (vtpp_pkg::QUO_W'(ge[l]) << BIT);
            end
            ovf_ff[k] <= ovf_ff[k-1];
            sgn_ff[k] <= sgn_ff[k-1];
            org_ff[k] <= org_ff[k-1];
         end
      end

      if (k < vtpp_pkg::QUO_W) begin : g_rem
         logic [vtpp_pkg::NUM_W-1:0] diff [vtpp_pkg::LANES];
         for (genvar l = 0; l < vtpp_pkg::LANES; l++) begin : g_sub
            assign diff[l] = rem_ff[k-1][l] - trial;
         end
         always_ff @(posedge clock) begin
            if (en[k]) begin
               den_ff[k] <= den_ff[k-1];
               for (int l = 0; l < vtpp_pkg::LANES; l++) begin
                  rem_ff[k][l] <= ge[l] ? diff[l] : rem_ff[k-1][l];
               end
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < vtpp_pkg::LANES; l++) begin
         quo.lane[l].quo = q_ff[vtpp_pkg::QUO_W][l];
         quo.lane[l].ovf = ovf_ff[vtpp_pkg::QUO_W][l];
         quo.lane[l].neg = sgn_ff[vtpp_pkg::QUO_W][l];
         quo.lane[l].org = org_ff[vtpp_pkg::QUO_W][l];
      end
   end

endmodule

FILE: rtl/vtpp_out.sv
// Signed offset plus screen origin, saturated to 16 bits, into the output register.
module vtpp_out (
   input  logic                              clock,
   input  logic                              en,
   input  vtpp_pkg::quo_type                 quo,
   output logic signed [vtpp_pkg::OUT_W-1:0] screen_x,
   output logic signed [vtpp_pkg::OUT_W-1:0] screen_y
);

   logic [vtpp_pkg::QUO_W-1:0]         mag_t  [vtpp_pkg::LANES];
   logic signed [vtpp_pkg::TERM_W-1:0] term   [vtpp_pkg::LANES];
   logic signed [vtpp_pkg::OSUM_W-1:0] osum   [vtpp_pkg::LANES];
   logic [vtpp_pkg::OUT_W-1:0]         scr_in [vtpp_pkg::LANES];
   logic [vtpp_pkg::OUT_W-1:0]         scr_ff [vtpp_pkg::LANES];

   always_comb begin
      for (int l = 0; l < vtpp_pkg::LANES; l++) begin
         mag_t[l] = quo.lane[l].ovf ? '1 : quo.lane[l].quo;
         term[l]  = quo.lane[l].neg ? -$signed({1'b0, mag_t[l]}) : $signed({1'b0, mag_t[l]});
         osum[l]  = vtpp_pkg::OSUM_W'($signed(quo.lane[l].org)) + vtpp_pkg::OSUM_W'(term[l]);
         if (osum[l] > vtpp_pkg::OSUM_W'(vtpp_pkg::SAT_MAX)) begin
            scr_in[l] = vtpp_pkg::SAT_MAX;
         end else if (osum[l] < vtpp_pkg::OSUM_W'(vtpp_pkg::SAT_MIN)) begin
            scr_in[l] = vtpp_pkg::SAT_MIN;
         end else begin
            scr_in[l] = osum[l][vtpp_pkg::OUT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         scr_ff <= scr_in;
      end
   end

   assign screen_x = scr_ff[vtpp_pkg::LANE_X];
   assign screen_y = scr_ff[vtpp_pkg::LANE_Y];

endmodule

FILE: rtl/view_transform_perspective_project_top.sv
// Top level: config registers, pipeline valid and stall control, datapath stages.
// Depth: 27 register stages from the item input to the rsp_ outputs.
// Throughput: one item per cycle while rsp_ready holds; most of the depth is the 18-stage restoring divider
// (overflow check, then one quotient bit per stage) between the multipliers and the output.
// Each stage loads when empty or when the stage after it moves, so bubbles close up.
// Reset (synchronous) empties the pipeline and loads the register defaults.
module view_transform_perspective_project_top (
   input  logic                                   clock,
   input  logic                                   reset,
   // item input
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [vtpp_pkg::PT_W-1:0]       req_point_x,
   input  logic signed [vtpp_pkg::PT_W-1:0]       req_point_y,
   input  logic signed [vtpp_pkg::PT_W-1:0]       req_point_z,
   input  logic signed [vtpp_pkg::ORG_W-1:0]      req_screen_origin_x,
   input  logic signed [vtpp_pkg::ORG_W-1:0]      req_screen_origin_y,
   input  logic [vtpp_pkg::SCALE_W-1:0]           req_view_scale,
   // item output
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [vtpp_pkg::OUT_W-1:0]      rsp_screen_x,
   output logic signed [vtpp_pkg::OUT_W-1:0]      rsp_screen_y,
   // register writes
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [vtpp_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [vtpp_pkg::CSR_DATA_W-1:0]        csr_data
);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [vtpp_pkg::POS_W-1:0]  camera_position_ff, camera_position_in;
   logic [vtpp_pkg::AXIS_W-1:0] right_axis_ff, right_axis_in;
   logic [vtpp_pkg::AXIS_W-1:0] up_axis_ff, up_axis_in;
   logic [vtpp_pkg::AXIS_W-1:0] forward_axis_ff, forward_axis_in;
   logic [vtpp_pkg::DIST_W-1:0] orbit_distance_ff, orbit_distance_in;
   logic [vtpp_pkg::DIST_W-1:0] near_limit_ff, near_limit_in;
   logic [vtpp_pkg::GAIN_W-1:0] focal_gain_ff, focal_gain_in;
   vtpp_pkg::cfg_type           cfg;

   // writes are always taken; an index past the list is dropped
   assign csr_ready = 1'b1;

   always_comb begin
      camera_position_in = camera_position_ff;
      right_axis_in      = right_axis_ff;
      up_axis_in         = up_axis_ff;
      forward_axis_in    = forward_axis_ff;
      orbit_distance_in  = orbit_distance_ff;
      near_limit_in      = near_limit_ff;
      focal_gain_in      = focal_gain_ff;
      if (csr_valid && csr_ready) begin
         unique case (vtpp_pkg::csr_index_type'(csr_index))
            vtpp_pkg::REG_CAMERA_POSITION: camera_position_in = csr_data[vtpp_pkg::POS_W-1:0];
            vtpp_pkg::REG_RIGHT_AXIS:      right_axis_in      = csr_data[vtpp_pkg::AXIS_W-1:0];
            vtpp_pkg::REG_UP_AXIS:         up_axis_in         = csr_data[vtpp_pkg::AXIS_W-1:0];
            vtpp_pkg::REG_FORWARD_AXIS:    forward_axis_in    = csr_data[vtpp_pkg::AXIS_W-1:0];
            vtpp_pkg::REG_ORBIT_DISTANCE:  orbit_distance_in  = csr_data[vtpp_pkg::DIST_W-1:0];
            vtpp_pkg::REG_NEAR_LIMIT:      near_limit_in      = csr_data[vtpp_pkg::DIST_W-1:0];
            vtpp_pkg::REG_FOCAL_GAIN:      focal_gain_in      = csr_data[vtpp_pkg::GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         camera_position_ff <= vtpp_pkg::CAMERA_POSITION_RST;
         right_axis_ff      <= vtpp_pkg::RIGHT_AXIS_RST;
         up_axis_ff         <= vtpp_pkg::UP_AXIS_RST;
         forward_axis_ff    <= vtpp_pkg::FORWARD_AXIS_RST;
         orbit_distance_ff  <= vtpp_pkg::ORBIT_DISTANCE_RST;
         near_limit_ff      <= vtpp_pkg::NEAR_LIMIT_RST;
         focal_gain_ff      <= vtpp_pkg::FOCAL_GAIN_RST;
      end else begin
         camera_position_ff <= camera_position_in;
         right_axis_ff      <= right_axis_in;
         up_axis_ff         <= up_axis_in;
         forward_axis_ff    <= forward_axis_in;
         orbit_distance_ff  <= orbit_distance_in;
         near_limit_ff      <= near_limit_in;
         focal_gain_ff      <= focal_gain_in;
      end
   end

   // unpack: x in the high slice, z in the low slice
   assign cfg.cam_x = camera_position_ff[3*vtpp_pkg::PT_W-1:2*vtpp_pkg::PT_W];
   assign cfg.cam_y = camera_position_ff[2*vtpp_pkg::PT_W-1:vtpp_pkg::PT_W];
   assign cfg.cam_z = camera_position_ff[vtpp_pkg::PT_W-1:0];
   assign cfg.rgt_x = right_axis_ff[3*vtpp_pkg::AX_W-1:2*vtpp_pkg::AX_W];
   assign cfg.rgt_y = right_axis_ff[2*vtpp_pkg::AX_W-1:vtpp_pkg::AX_W];
   assign cfg.rgt_z = right_axis_ff[vtpp_pkg::AX_W-1:0];
   assign cfg.up_x  = up_axis_ff[3*vtpp_pkg::AX_W-1:2*vtpp_pkg::AX_W];
   assign cfg.up_y  = up_axis_ff[2*vtpp_pkg::AX_W-1:vtpp_pkg::AX_W];
   assign cfg.up_z  = up_axis_ff[vtpp_pkg::AX_W-1:0];
   assign cfg.fwd_x = forward_axis_ff[3*vtpp_pkg::AX_W-1:2*vtpp_pkg::AX_W];
   assign cfg.fwd_y = forward_axis_ff[2*vtpp_pkg::AX_W-1:vtpp_pkg::AX_W];
   assign cfg.fwd_z = forward_axis_ff[vtpp_pkg::AX_W-1:0];
   assign cfg.orbit = orbit_distance_ff;
   assign cfg.near  = near_limit_ff;
   assign cfg.gain  = focal_gain_ff;

   // ---------------------------------------------------------------
   // Stage valids and advance chain.
   // adv[k]: stage k loads this cycle (it is empty, or its item moves on).
   // adv[NST] is the output handshake.
   // ---------------------------------------------------------------
   logic [vtpp_pkg::NST-1:0] vld_ff, vld_in;
   logic [vtpp_pkg::NST:0]   adv;

   assign adv[vtpp_pkg::NST] = rsp_ready;
   for (genvar k = 0; k < vtpp_pkg::NST; k++) begin : g_adv
      assign adv[k] = !vld_ff[k] || adv[k+1];
   end

   assign vld_in[0] = adv[0] ? req_valid : vld_ff[0];
   for (genvar k = 1; k < vtpp_pkg::NST; k++) begin : g_vld
      assign vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = vld_ff[vtpp_pkg::OUT_STAGE];

   // ---------------------------------------------------------------
   // Datapath
   // ---------------------------------------------------------------
   vtpp_pkg::view_type view_w;
   vtpp_pkg::num_type  num_w;
   vtpp_pkg::quo_type  quo_w;

   // relative point, dot products, depth clamp, magnitudes
   vtpp_view u_view (
      .clock   (clock),
      .cfg     (cfg),
      .en      (adv[vtpp_pkg::VIEW_FIRST +: vtpp_pkg::VIEW_N]),
      .point_x (req_point_x),
      .point_y (req_point_y),
      .point_z (req_point_z),
      .org_x   (req_screen_origin_x),
      .org_y   (req_screen_origin_y),
      .scale   (req_view_scale),
      .view    (view_w)
   );

   // numerator |v| * gain * scale
   vtpp_scale u_scale (
      .clock (clock),
      .gain  (cfg.gain),
      .en    (adv[vtpp_pkg::SCL_FIRST +: vtpp_pkg::SCL_N]),
      .view  (view_w),
      .num   (num_w)
   );

   // divide by depth * 2^16, one bit a stage
   vtpp_div u_div (
      .clock (clock),
      .en    (adv[vtpp_pkg::DIV_FIRST +: vtpp_pkg::DIV_N]),
      .num   (num_w),
      .quo   (quo_w)
   );

   // sign, origin, saturation, output register
   vtpp_out u_out (
      .clock    (clock),
      .en       (adv[vtpp_pkg::OUT_STAGE]),
      .quo      (quo_w),
      .screen_x (rsp_screen_x),
      .screen_y (rsp_screen_y)
   );

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   // input is refused only when every stage holds an item
   a_no_bubble_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> &vld_ff)
      else $error("input refused with an empty stage");

   // clamped depth never falls below the smallest near limit
   a_depth_floor: assert property (@(posedge clock) disable iff (reset)
      vld_ff[vtpp_pkg::VIEW_N-1] |-> view_w.depth >= vtpp_pkg::DEPTH_MIN)
      else $error("depth below near floor");

   // divider overflow on a positive x offset saturates high
   a_ovf_x_high: assert property (@(posedge clock) disable iff (reset)
      vld_ff[vtpp_pkg::OUT_STAGE-1] && adv[vtpp_pkg::OUT_STAGE]
      && quo_w.lane[vtpp_pkg::LANE_X].ovf && !quo_w.lane[vtpp_pkg::LANE_X].neg
      |=> rsp_screen_x == vtpp_pkg::SAT_MAX)
      else $error("x overflow not saturated high");

   // divider overflow on a negative y offset saturates low
   a_ovf_y_low: assert property (@(posedge clock) disable iff (reset)
      vld_ff[vtpp_pkg::OUT_STAGE-1] && adv[vtpp_pkg::OUT_STAGE]
      && quo_w.lane[vtpp_pkg::LANE_Y].ovf && quo_w.lane[vtpp_pkg::LANE_Y].neg
      |=> rsp_screen_y == vtpp_pkg::SAT_MIN)
      else $error("y overflow not saturated low");

endmodule
